// ===== rtl/keyword_mask_filter_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Keyword mask filter assertion macros
// Concurrent assertion wrappers that can be compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef KEYWORD_MASK_FILTER_UNIT_ASSERT_SVH
`define KEYWORD_MASK_FILTER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Antecedent and consequent in the same cycle.
`define KMF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("keyword mask filter check failed");

// Consequent in the cycle after the antecedent.
`define KMF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("keyword mask filter check failed");

`else

`define KMF_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define KMF_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/kmf_pkg.sv =====
// ----------------------------------------------------------------------------
// Keyword mask filter package
// Keyword table, case folding and the control type shared by the modules.
// ----------------------------------------------------------------------------
package kmf_pkg;

  localparam int KwCount  = 3;
  localparam int KwMaxLen = 12;

  typedef logic [8*KwMaxLen-1:0] kw_text_t;

  // Right aligned: the last character of a keyword sits in bits [7:0], so
  // the byte at age a (0 = newest) is compared with bits [8*a+7:8*a].
  localparam kw_text_t KwText [KwCount] = '{
    kw_text_t'("palavraofeia"),
    kw_text_t'("chulao"),
    kw_text_t'("improprio")
  };

  localparam int KwLen [KwCount] = '{12, 6, 9};

  localparam logic [7:0] StarChar = 8'd42;

  // Control from the window to the output stage for one accepted byte.
  typedef struct packed {
    logic emit_one;    // oldest byte leaves the full window
    logic load_flush;  // last byte: whole window moves to the flush buffer
  } kmf_push_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'd65 && c <= 8'd90) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

endpackage

// ===== rtl/kmf_window.sv =====
// ----------------------------------------------------------------------------
// Keyword mask filter window
// Holds the unreleased bytes with their mask bits and matches the keywords.
// ----------------------------------------------------------------------------
module kmf_window import kmf_pkg::*; #(
  parameter int WindowLen = 12
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               accept_i,
  input  logic [7:0]                         char_i,
  input  logic                               last_i,
  output kmf_push_t                          push_o,
  output logic [$clog2(WindowLen+1)-1:0]     n_o,
  output logic [7:0]                         single_o,
  output logic [7:0]                         win_o [WindowLen]
);

  localparam int FillW     = $clog2(WindowLen);
  localparam int CntW      = $clog2(WindowLen + 1);
  localparam int HoldDepth = WindowLen - 1;

  logic [7:0]           held_q [HoldDepth];
  logic [HoldDepth-1:0] mark_q, mark_d;
  logic [FillW-1:0]     fill_q, fill_d;

  logic [7:0]           ext_byte [WindowLen];
  logic [WindowLen-1:0] ext_mark;
  logic [KwCount-1:0]   hit;
  logic [CntW-1:0]      n;
  logic                 full;

  // Age 0 is the incoming byte, age a is the byte a positions older.
  always_comb begin
    ext_byte[0] = char_i;
    for (int a = 1; a < WindowLen; a++) begin
      ext_byte[a] = held_q[a-1];
    end
  end

  // A keyword ends at the incoming byte if enough bytes are held and every
  // folded byte equals the keyword character at the same age.
  always_comb begin
    for (int k = 0; k < KwCount; k++) begin
      hit[k] = (fill_q >= FillW'(KwLen[k] - 1));
      for (int a = 0; a < KwMaxLen; a++) begin
        if (a < KwLen[k]) begin
          hit[k] = hit[k] & (fold_case(ext_byte[a]) == KwText[k][8*a +: 8]);
        end
      end
    end
  end

  always_comb begin
    ext_mark = '0;
    for (int a = 1; a < WindowLen; a++) begin
      ext_mark[a] = mark_q[a-1];
    end
    for (int k = 0; k < KwCount; k++) begin
      for (int a = 0; a < KwMaxLen; a++) begin
        if (a < KwLen[k] && hit[k]) begin
          ext_mark[a] = 1'b1;
        end
      end
    end
    for (int a = 0; a < WindowLen; a++) begin
      win_o[a] = ext_mark[a] ? StarChar : ext_byte[a];
    end
  end

  assign n    = CntW'(fill_q) + CntW'(1);
  assign full = (n == CntW'(WindowLen));
  assign n_o  = n;

  // The oldest byte in the extended window sits at age fill_q.
  assign single_o = win_o[fill_q];

  assign push_o.emit_one   = accept_i & ~last_i & full;
  assign push_o.load_flush = accept_i & last_i;

  always_comb begin
    if (last_i) begin
      mark_d = '0;
      fill_d = '0;
    end else begin
      mark_d = ext_mark[HoldDepth-1:0];
      fill_d = full ? FillW'(HoldDepth) : n[FillW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mark_q <= '0;
      fill_q <= '0;
    end else if (accept_i) begin
      mark_q <= mark_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      for (int j = 0; j < HoldDepth; j++) begin
        held_q[j] <= ext_byte[j];
      end
    end
  end

endmodule

// ===== rtl/kmf_drain.sv =====
// ----------------------------------------------------------------------------
// Keyword mask filter output stage
// Flush buffer for the end of a message and the output register.
// ----------------------------------------------------------------------------
module kmf_drain import kmf_pkg::*; #(
  parameter int WindowLen = 12
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  kmf_push_t                          push_i,
  input  logic [$clog2(WindowLen+1)-1:0]     n_i,
  input  logic [7:0]                         single_i,
  input  logic [7:0]                         win_i [WindowLen],
  input  logic                               out_ready_i,
  output logic                               ready_o,
  output logic                               busy_o,
  output logic                               out_valid_o,
  output logic [7:0]                         out_char_o,
  output logic                               out_last_o
);

  localparam int CntW = $clog2(WindowLen + 1);
  localparam int IdxW = $clog2(WindowLen);

  logic [7:0]      fbuf_q [WindowLen];
  logic [CntW-1:0] cnt_q;
  logic [CntW-1:0] cnt_m1;
  logic            out_valid_q;
  logic [7:0]      out_char_q;
  logic            out_last_q;
  logic            take;
  logic            drain;

  assign take   = ~out_valid_q | out_ready_i;
  assign busy_o = (cnt_q != '0);
  assign drain  = busy_o & take;
  assign cnt_m1 = cnt_q - CntW'(1);

  // A push only comes with an accepted byte, which needs an idle flush buffer
  // and a free output register.
  assign ready_o = ~busy_o & take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (push_i.load_flush) begin
        cnt_q <= n_i;
      end else if (drain) begin
        cnt_q <= cnt_m1;
      end
      if (push_i.emit_one || drain) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Entries drain from the oldest age down to age zero, the final byte.
  always_ff @(posedge clk_i) begin
    if (push_i.load_flush) begin
      fbuf_q <= win_i;
    end
    if (push_i.emit_one) begin
      out_char_q <= single_i;
      out_last_q <= 1'b0;
    end else if (drain) begin
      out_char_q <= fbuf_q[cnt_m1[IdxW-1:0]];
      out_last_q <= (cnt_q == CntW'(1));
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;

endmodule

// ===== rtl/keyword_mask_filter_unit.sv =====
// ----------------------------------------------------------------------------
// Keyword mask filter unit
// Masks the keywords of a byte stream with asterisks, message by message.
// ----------------------------------------------------------------------------
// The unit takes one message byte per transfer and returns the same bytes in
// order, with every byte covered by an occurrence of "palavraofeia", "chulao"
// or "improprio" (ASCII letters compared case-insensitively, overlaps
// included) replaced by an asterisk. Inside a message a byte is held until
// WINDOW_LEN-1 later bytes have arrived, so output lags input by up to
// WINDOW_LEN-1 bytes; while that window is full, every accepted byte releases
// one output transfer and bytes stream at one per cycle while out_ready_i
// holds. The byte flagged as last releases the whole held window: it moves
// into a flush buffer that drains one output transfer per cycle while
// out_ready_i holds, oldest first, with last_out_o set on the final byte.
// Input is stalled while that drain runs, until the up to WINDOW_LEN held
// bytes have left. The window is cleared by the last byte, so matches never
// span two messages. An output register separates the two sides: a new byte
// is taken while the previous result is being transferred.
// ----------------------------------------------------------------------------
module keyword_mask_filter_unit import kmf_pkg::*; #(
  parameter int WINDOW_LEN = 12
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_in_i,
  input  logic       last_in_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] char_out_o,
  output logic       last_out_o
);

`include "keyword_mask_filter_unit_assert.svh"

  localparam int CntW = $clog2(WINDOW_LEN + 1);

  kmf_push_t       push;
  logic [CntW-1:0] win_n;
  logic [7:0]      win_single;
  logic [7:0]      win_bytes [WINDOW_LEN];
  logic            accept;
  logic            drain_ready;
  logic            drain_busy;

  assign in_ready_o = drain_ready;
  assign accept     = in_valid_i & drain_ready;

  // Window and keyword matchers: all three keywords are checked in parallel
  // against the newest bytes on every accepted transfer.
  kmf_window #(
    .WindowLen (WINDOW_LEN)
  ) u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .char_i   (char_in_i),
    .last_i   (last_in_i),
    .push_o   (push),
    .n_o      (win_n),
    .single_o (win_single),
    .win_o    (win_bytes)
  );

  // Output register plus the flush buffer that empties at message end.
  kmf_drain #(
    .WindowLen (WINDOW_LEN)
  ) u_drain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .n_i         (win_n),
    .single_i    (win_single),
    .win_i       (win_bytes),
    .out_ready_i (out_ready_i),
    .ready_o     (drain_ready),
    .busy_o      (drain_busy),
    .out_valid_o (out_valid_o),
    .out_char_o  (char_out_o),
    .out_last_o  (last_out_o)
  );

  // The last byte of a message always starts a flush drain.
  `KMF_ASSERT_NEXT(a_last_starts_flush, clk_i, rst_ni, accept && last_in_i, drain_busy)

  // The final byte of a message only leaves once the flush buffer is empty.
  `KMF_ASSERT_SAME(a_last_ends_flush, clk_i, rst_ni, out_valid_o && last_out_o, !drain_busy)

  // Neither a single release nor a flush load is pushed while the flush buffer is busy.
  `KMF_ASSERT_SAME(a_no_push_in_flush, clk_i, rst_ni, drain_busy,
                   !push.emit_one && !push.load_flush)

endmodule
